[rtl/emcd_pkg.sv]
// shared constants, payload types and constant dividers for the epoch to civil date converter
package emcd_pkg;

  // field widths
  localparam int MS_W     = 44;
  localparam int TDATA_W  = 48;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int MSEC_W   = 10;

  // millisecond divider slices the count into chunks, one per stage
  localparam int CHUNK_W   = 11;
  localparam int MS_STAGES = MS_W / CHUNK_W;
  localparam int SECS_W    = 35;
  localparam int DAYS_W    = 18;
  localparam int DNUM_W    = 20;
  localparam int DOE_W     = 18;
  localparam int YOE_W     = 9;
  localparam int DOY_W     = 9;
  localparam int ERA_W     = 3;
  localparam int MP_W      = 4;

  // calendar constants
  localparam int D_MS        = 1000;
  localparam int D_675       = 675;
  localparam int D_225       = 225;
  localparam int D_15        = 15;
  localparam int D_YEAR      = 365;
  localparam int D_153       = 153;
  localparam int ERA_DAYS    = 146097;
  localparam int CENT_DAYS   = 36524;
  localparam int ERA_YEARS   = 400;
  localparam int EPOCH_SHIFT = 719468;

  // reciprocals: floor(2^sh / d), sh chosen above the input width
  localparam int SH_1000 = 31;
  localparam int SH_675  = 29;
  localparam int SH_225  = 16;
  localparam int SH_15   = 16;
  localparam int SH_ERA  = 32;
  localparam int SH_365  = 27;
  localparam int SH_153  = 16;
  localparam logic [21:0] RCP_1000 = 22'((64'd1 << SH_1000) / 64'd1000);
  localparam logic [19:0] RCP_675  = 20'((64'd1 << SH_675) / 64'd675);
  localparam logic [8:0]  RCP_225  = 9'((64'd1 << SH_225) / 64'd225);
  localparam logic [12:0] RCP_15   = 13'((64'd1 << SH_15) / 64'd15);
  localparam logic [14:0] RCP_ERA  = 15'((64'd1 << SH_ERA) / 64'd146097);
  localparam logic [18:0] RCP_365  = 19'((64'd1 << SH_365) / 64'd365);
  localparam logic [8:0]  RCP_153  = 9'((64'd1 << SH_153) / 64'd153);

  typedef struct packed {
    logic [SECS_W-1:0] secs;
    logic [MSEC_W-1:0] msec;
  } msec_split_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [MSEC_W-1:0] millisecond;
  } tod_t;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    tod_t              tod;
  } day_tod_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    tod_t               tod;
  } civil_t;

  // each divider: estimate by reciprocal, estimate is exact or one low, one fixup step
  function automatic void div1000(input logic [20:0] v, output logic [10:0] q,
                                  output logic [9:0] r);
    logic [42:0] prod;
    logic [10:0] q0;
    logic [20:0] r0;
    prod = 43'(v) * 43'(RCP_1000);
    q0   = 11'(prod >> SH_1000);
    r0   = v - 21'(q0) * 21'(D_MS);
    if (r0 >= 21'(D_MS)) begin
      q = q0 + 11'd1;
      r = 10'(r0 - 21'(D_MS));
    end else begin
      q = q0;
      r = 10'(r0);
    end
  endfunction

  function automatic void div675(input logic [27:0] v, output logic [18:0] q,
                                 output logic [9:0] r);
    logic [47:0] prod;
    logic [18:0] q0;
    logic [27:0] r0;
    prod = 48'(v) * 48'(RCP_675);
    q0   = 19'(prod >> SH_675);
    r0   = v - 28'(q0) * 28'(D_675);
    if (r0 >= 28'(D_675)) begin
      q = q0 + 19'd1;
      r = 10'(r0 - 28'(D_675));
    end else begin
      q = q0;
      r = 10'(r0);
    end
  endfunction

  function automatic void div225(input logic [12:0] v, output logic [5:0] q,
                                 output logic [7:0] r);
    logic [21:0] prod;
    logic [5:0]  q0;
    logic [12:0] r0;
    prod = 22'(v) * 22'(RCP_225);
    q0   = 6'(prod >> SH_225);
    r0   = v - 13'(q0) * 13'(D_225);
    if (r0 >= 13'(D_225)) begin
      q = q0 + 6'd1;
      r = 8'(r0 - 13'(D_225));
    end else begin
      q = q0;
      r = 8'(r0);
    end
  endfunction

  function automatic void div15(input logic [9:0] v, output logic [6:0] q,
                                output logic [3:0] r);
    logic [22:0] prod;
    logic [6:0]  q0;
    logic [9:0]  r0;
    prod = 23'(v) * 23'(RCP_15);
    q0   = 7'(prod >> SH_15);
    r0   = v - 10'(q0) * 10'(D_15);
    if (r0 >= 10'(D_15)) begin
      q = q0 + 7'd1;
      r = 4'(r0 - 10'(D_15));
    end else begin
      q = q0;
      r = 4'(r0);
    end
  endfunction

  function automatic void div_era(input logic [DNUM_W-1:0] v, output logic [ERA_W-1:0] q,
                                  output logic [DOE_W-1:0] r);
    logic [34:0]       prod;
    logic [ERA_W-1:0]  q0;
    logic [DNUM_W-1:0] r0;
    prod = 35'(v) * 35'(RCP_ERA);
    q0   = ERA_W'(prod >> SH_ERA);
    r0   = v - DNUM_W'(q0) * DNUM_W'(ERA_DAYS);
    if (r0 >= DNUM_W'(ERA_DAYS)) begin
      q = q0 + ERA_W'(1);
      r = DOE_W'(r0 - DNUM_W'(ERA_DAYS));
    end else begin
      q = q0;
      r = DOE_W'(r0);
    end
  endfunction

  function automatic logic [9:0] div365(input logic [17:0] v);
    logic [36:0] prod;
    logic [9:0]  q0;
    logic [17:0] r0;
    prod = 37'(v) * 37'(RCP_365);
    q0   = 10'(prod >> SH_365);
    r0   = v - 18'(q0) * 18'(D_YEAR);
    return (r0 >= 18'(D_YEAR)) ? q0 + 10'd1 : q0;
  endfunction

  function automatic logic [MP_W-1:0] div153(input logic [10:0] v);
    logic [19:0]     prod;
    logic [MP_W-1:0] q0;
    logic [10:0]     r0;
    prod = 20'(v) * 20'(RCP_153);
    q0   = MP_W'(prod >> SH_153);
    r0   = v - 11'(q0) * 11'(D_153);
    return (r0 >= 11'(D_153)) ? q0 + MP_W'(1) : q0;
  endfunction

  // first day of each month in the march-based year, (153*mp+2)/5
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

[rtl/emcd_msec_div.sv]
// chunked pipelined divide of the millisecond count by 1000
module emcd_msec_div import emcd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [MS_W-1:0] in_ms,
  output logic            out_valid,
  input  logic            out_ready,
  output msec_split_t     out_data
);

  logic [MS_STAGES-1:0] vld;
  logic [MS_STAGES-1:0] en;
  logic [MS_STAGES-1:0] vin;
  logic [MS_W-1:0]      src      [MS_STAGES];
  logic [MS_W-1:0]      quo      [MS_STAGES];
  logic [MSEC_W-1:0]    rem      [MS_STAGES];
  logic [MS_W-1:0]      src_in   [MS_STAGES];
  logic [MS_W-1:0]      quo_in   [MS_STAGES];
  logic [MSEC_W-1:0]    rem_in   [MS_STAGES];
  logic [CHUNK_W-1:0]   qd       [MS_STAGES];
  logic [MSEC_W-1:0]    rd       [MS_STAGES];
  logic [MS_W-1:0]      src_next [MS_STAGES];
  logic [MS_W-1:0]      quo_next [MS_STAGES];

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[MS_STAGES-1] = !vld[MS_STAGES-1] || out_ready;
    for (int s = MS_STAGES - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  always_comb begin
    vin[0]    = in_valid;
    src_in[0] = in_ms;
    quo_in[0] = '0;
    rem_in[0] = '0;
    for (int s = 1; s < MS_STAGES; s++) begin
      vin[s]    = vld[s-1];
      src_in[s] = src[s-1];
      quo_in[s] = quo[s-1];
      rem_in[s] = rem[s-1];
    end
    // long division by 1000, one chunk of the count per stage, msb chunk first
    for (int s = 0; s < MS_STAGES; s++) begin
      div1000({rem_in[s], src_in[s][MS_W-1 -: CHUNK_W]}, qd[s], rd[s]);
      src_next[s] = src_in[s] << CHUNK_W;
      quo_next[s] = {quo_in[s][MS_W-CHUNK_W-1:0], qd[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < MS_STAGES; s++) begin
        if (en[s]) begin
          vld[s] <= vin[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < MS_STAGES; s++) begin
      if (en[s]) begin
        src[s] <= src_next[s];
        quo[s] <= quo_next[s];
        rem[s] <= rd[s];
      end
    end
  end

  assign in_ready       = en[0];
  assign out_valid      = vld[MS_STAGES-1];
  assign out_data.secs  = quo[MS_STAGES-1][SECS_W-1:0];
  assign out_data.msec  = rem[MS_STAGES-1];

endmodule

[rtl/emcd_tod_split.sv]
// splits seconds into whole days and hour, minute, second of the day
module emcd_tod_split import emcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  msec_split_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output day_tod_t    out_data
);

  logic [2:0]        vld;
  logic [2:0]        en;

  logic [DAYS_W-1:0] b0_days;
  logic [16:0]       b0_sod;
  logic [MSEC_W-1:0] b0_msec;
  logic [DAYS_W-1:0] b1_days;
  logic [HOUR_W-1:0] b1_hour;
  logic [11:0]       b1_rem;
  logic [MSEC_W-1:0] b1_msec;
  day_tod_t          b2;

  logic [18:0]       q675;
  logic [9:0]        r675;
  logic [5:0]        q225;
  logic [7:0]        r225;
  logic [6:0]        q15;
  logic [3:0]        r15;

  always_comb begin
    en[2] = !vld[2] || out_ready;
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
  end

  // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15: low bits pass straight into the remainder
  always_comb begin
    div675(in_data.secs[SECS_W-1:7], q675, r675);
    div225(b0_sod[16:4], q225, r225);
    div15(b1_rem[11:2], q15, r15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      if (en[1]) begin
        vld[1] <= vld[0];
      end
      if (en[2]) begin
        vld[2] <= vld[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      b0_days <= q675[DAYS_W-1:0];
      b0_sod  <= {r675, in_data.secs[6:0]};
      b0_msec <= in_data.msec;
    end
    if (en[1]) begin
      b1_days <= b0_days;
      b1_hour <= q225[HOUR_W-1:0];
      b1_rem  <= {r225, b0_sod[3:0]};
      b1_msec <= b0_msec;
    end
    if (en[2]) begin
      b2.days            <= b1_days;
      b2.tod.hour        <= b1_hour;
      b2.tod.minute      <= q15[MIN_W-1:0];
      b2.tod.second      <= {r15, b1_rem[1:0]};
      b2.tod.millisecond <= b1_msec;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[2];
  assign out_data  = b2;

endmodule

[rtl/emcd_civil.sv]
// day count to proleptic gregorian year, month and day of month
module emcd_civil import emcd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  day_tod_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output civil_t   out_data
);

  localparam int NS = 7;

  logic [NS-1:0]      vld;
  logic [NS-1:0]      en;

  logic [DNUM_W-1:0]  c0_d;
  tod_t               c0_tod;
  logic [ERA_W-1:0]   c1_era;
  logic [DOE_W-1:0]   c1_doe;
  tod_t               c1_tod;
  logic [DOE_W-1:0]   c2_n;
  logic [DOE_W-1:0]   c2_doe;
  logic [ERA_W-1:0]   c2_era;
  tod_t               c2_tod;
  logic [YOE_W-1:0]   c3_yoe;
  logic [DOE_W-1:0]   c3_doe;
  logic [ERA_W-1:0]   c3_era;
  tod_t               c3_tod;
  logic [DOY_W-1:0]   c4_doy;
  logic [YEAR_W-1:0]  c4_ybase;
  tod_t               c4_tod;
  logic [MP_W-1:0]    c5_mp;
  logic [DOY_W-1:0]   c5_doy;
  logic [YEAR_W-1:0]  c5_ybase;
  tod_t               c5_tod;
  civil_t             c6;

  logic [ERA_W-1:0]   era_q;
  logic [DOE_W-1:0]   doe_r;
  logic [9:0]         quad_q;
  logic [2:0]         cent;
  logic               last_day;
  logic [9:0]         yoe_q;
  logic [1:0]         c100;
  logic [MONTH_W-1:0] mon;

  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  always_comb begin
    div_era(c0_d, era_q, doe_r);
    // doe/1460 taken as (doe/4)/365
    quad_q   = div365({2'b00, c1_doe[DOE_W-1:2]});
    cent     = 3'(c1_doe >= DOE_W'(CENT_DAYS)) + 3'(c1_doe >= DOE_W'(2 * CENT_DAYS))
             + 3'(c1_doe >= DOE_W'(3 * CENT_DAYS)) + 3'(c1_doe >= DOE_W'(4 * CENT_DAYS));
    last_day = (c1_doe == DOE_W'(ERA_DAYS - 1));
    yoe_q    = div365(c2_n);
    c100     = 2'(c3_yoe >= YOE_W'(100)) + 2'(c3_yoe >= YOE_W'(200))
             + 2'(c3_yoe >= YOE_W'(300));
    // march-based month index back to january-based month
    mon      = (c5_mp < MP_W'(10)) ? MONTH_W'(c5_mp + MP_W'(3)) : MONTH_W'(c5_mp - MP_W'(9));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c0_d   <= DNUM_W'(in_data.days) + DNUM_W'(EPOCH_SHIFT);
      c0_tod <= in_data.tod;
    end
    if (en[1]) begin
      c1_era <= era_q;
      c1_doe <= doe_r;
      c1_tod <= c0_tod;
    end
    if (en[2]) begin
      c2_n   <= c1_doe - DOE_W'(quad_q) + DOE_W'(cent) - DOE_W'(last_day);
      c2_doe <= c1_doe;
      c2_era <= c1_era;
      c2_tod <= c1_tod;
    end
    if (en[3]) begin
      c3_yoe <= yoe_q[YOE_W-1:0];
      c3_doe <= c2_doe;
      c3_era <= c2_era;
      c3_tod <= c2_tod;
    end
    if (en[4]) begin
      c4_doy   <= DOY_W'(c3_doe - (DOE_W'(c3_yoe) * DOE_W'(D_YEAR)
                  + DOE_W'(c3_yoe[YOE_W-1:2]) - DOE_W'(c100)));
      c4_ybase <= YEAR_W'(c3_yoe) + YEAR_W'(c3_era) * YEAR_W'(ERA_YEARS);
      c4_tod   <= c3_tod;
    end
    if (en[5]) begin
      c5_mp    <= div153(11'(c4_doy) * 11'(5) + 11'd2);
      c5_doy   <= c4_doy;
      c5_ybase <= c4_ybase;
      c5_tod   <= c4_tod;
    end
    if (en[6]) begin
      c6.year  <= c5_ybase + YEAR_W'(mon <= MONTH_W'(2));
      c6.month <= mon;
      c6.day   <= DAY_W'(c5_doy - month_start(c5_mp) + DOY_W'(1));
      c6.tod   <= c5_tod;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];
  assign out_data  = c6;

endmodule

[rtl/epoch_ms_to_civil_datetime.sv]
// Millisecond epoch timestamp to civil date and time of day, stream top level.
//
// Input beat: s_axis_tdata[43:0] holds milliseconds since 1970-01-01 00:00:00,
// bits [47:44] are ignored. Output beat: one per input beat, in order, with
// year, month, day, hour, minute, second and millisecond packed in m_axis_tdata.
//
// From input acceptance to the output beat showing on m_axis_tvalid, 4 stages
// divide the count by 1000 one 11-bit chunk at a time, 3 stages split seconds
// into days, hours, minutes and seconds, and 7 stages run the era /
// year-of-era / month chain of the day-to-date conversion. Throughput is one
// beat per cycle while m_axis_tready does not stall the pipeline.
//
// Every stage carries its own valid bit and holds only when it is full and the
// stage after it holds, so a stall on m_axis_tready fills the empty stages
// before s_axis_tready drops; nothing is dropped or repeated. Reset clears the
// valid bits only, so the pipeline comes out of reset empty.
module epoch_ms_to_civil_datetime import emcd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // epoch_millis[43:0], zero pad [47:44]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata    // year, month, day, hour, minute, second,
                                             // millisecond from bit 0 up
);

  logic        ms_valid;
  logic        ms_ready;
  msec_split_t ms_data;
  logic        tod_valid;
  logic        tod_ready;
  day_tod_t    tod_data;
  civil_t      res;

  emcd_msec_div u_msec_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_ms     (s_axis_tdata[MS_W-1:0]),
    .out_valid (ms_valid),
    .out_ready (ms_ready),
    .out_data  (ms_data)
  );

  emcd_tod_split u_tod_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ms_valid),
    .in_ready  (ms_ready),
    .in_data   (ms_data),
    .out_valid (tod_valid),
    .out_ready (tod_ready),
    .out_data  (tod_data)
  );

  emcd_civil u_civil (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tod_valid),
    .in_ready  (tod_ready),
    .in_data   (tod_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = {res.tod.millisecond, res.tod.second, res.tod.minute, res.tod.hour,
                         res.day, res.month, res.year};

  // every 44-bit count lands on a legal calendar date and time
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.month >= MONTH_W'(1) && res.month <= MONTH_W'(12)))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.day >= DAY_W'(1) && res.day <= DAY_W'(31)))
    else $error("day of month out of range");

  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.tod.hour <= HOUR_W'(23) && res.tod.minute <= MIN_W'(59)
                       && res.tod.second <= SEC_W'(59)
                       && res.tod.millisecond <= MSEC_W'(999)))
    else $error("time of day out of range");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.year >= YEAR_W'(1970) && res.year <= YEAR_W'(2527)))
    else $error("year out of range");

endmodule
